// ===== src/pwle_pkg.sv =====
// Shared types, constants and helper functions of the pixel line encoder.
`timescale 1ns / 1ps

package pwle_pkg;

  localparam int unsigned MAX_LEDS    = 256;
  localparam int unsigned STORE_BYTES = 3 * MAX_LEDS;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned TICK_W      = 10;
  localparam int unsigned LED_W       = 9;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 3'd5;

  typedef enum logic [1:0] {
    PH_GAP,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] position;
    logic [7:0]        value;
    logic              commit;
  } in_item_t;

  typedef struct packed {
    logic       line_level;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] gap;
    logic [LED_W-1:0]  led_count;
  } timing_cfg_t;

  typedef struct packed {
    logic       tick;
    logic       start;
    logic [7:0] start_byte;
  } tmr_ctrl_t;

  typedef struct packed {
    logic              refreshing;
    logic              line_next;
    logic              busy_next;
    logic              fetch_req;
    logic [ADDR_W-1:0] fetch_addr;
  } tmr_stat_t;

  function automatic logic [ADDR_W-1:0] total_bytes(input logic [LED_W-1:0] led);
    logic [ADDR_W-1:0] n;
    if (ADDR_W'(led) > ADDR_W'(MAX_LEDS)) begin
      n = ADDR_W'(MAX_LEDS);
    end else begin
      n = ADDR_W'(led);
    end
    return (n << 1) + n;
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== src/pwle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pwle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 768,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pwle_bit_timer.sv =====
// Refresh sequencer: bit and phase timing of the serial line and the byte prefetch.
`timescale 1ns / 1ps

module pwle_bit_timer (
  input  logic                 clk,
  input  logic                 rst,
  input  pwle_pkg::timing_cfg_t cfg,
  input  pwle_pkg::tmr_ctrl_t   ctrl,
  input  logic [7:0]           rdata,
  output pwle_pkg::tmr_stat_t   stat
);

  logic                          refreshing;
  logic                          refreshing_next;
  logic [pwle_pkg::ADDR_W-1:0]   byte_index;
  logic [pwle_pkg::ADDR_W-1:0]   byte_index_next;
  logic [2:0]                    bit_index;
  logic [2:0]                    bit_index_next;
  pwle_pkg::phase_t              bit_phase;
  pwle_pkg::phase_t              bit_phase_next;
  logic [pwle_pkg::TICK_W-1:0]   phase_count;
  logic [pwle_pkg::TICK_W-1:0]   phase_count_next;
  logic                          line_out;
  logic                          line_out_next;
  logic [7:0]                    cur_byte;
  logic [7:0]                    cur_byte_next;
  logic [7:0]                    next_byte;
  logic                          pf_pending;
  logic                          pf_pending_next;
  logic                          pf_inflight;

  logic                          cur_bit;
  logic [pwle_pkg::ADDR_W-1:0]   total;
  pwle_pkg::phase_t              ph1;
  logic [pwle_pkg::TICK_W-1:0]   cnt1;
  logic [pwle_pkg::TICK_W-1:0]   cnt2;
  logic [pwle_pkg::TICK_W-1:0]   dur;
  logic [pwle_pkg::ADDR_W-1:0]   byte_new;
  logic                          adv_byte;

  assign cur_bit = cur_byte[3'd7 - bit_index];
  assign total   = pwle_pkg::total_bytes(cfg.led_count);

  always_comb begin
    refreshing_next  = refreshing;
    byte_index_next  = byte_index;
    bit_index_next   = bit_index;
    bit_phase_next   = bit_phase;
    phase_count_next = phase_count;
    line_out_next    = line_out;
    cur_byte_next    = cur_byte;
    pf_pending_next  = 1'b0;
    ph1              = bit_phase;
    cnt1             = phase_count;
    cnt2             = phase_count;
    dur              = cfg.gap;
    byte_new         = byte_index;
    adv_byte         = 1'b0;
    if (ctrl.start) begin
      refreshing_next  = 1'b1;
      byte_index_next  = '0;
      bit_index_next   = '0;
      bit_phase_next   = pwle_pkg::PH_GAP;
      phase_count_next = '0;
      line_out_next    = 1'b0;
      cur_byte_next    = ctrl.start_byte;
      pf_pending_next  = 1'b1;
    end else if (ctrl.tick && refreshing) begin
      if (bit_phase == pwle_pkg::PH_GAP && phase_count >= cfg.gap) begin
        ph1  = pwle_pkg::PH_HIGH;
        cnt1 = '0;
      end
      line_out_next = (ph1 == pwle_pkg::PH_HIGH);
      cnt2 = cnt1 + 1'b1;
      unique case (ph1)
        pwle_pkg::PH_GAP:  dur = cfg.gap;
        pwle_pkg::PH_HIGH: dur = pwle_pkg::at_least_one(cur_bit ? cfg.one_high : cfg.zero_high);
        pwle_pkg::PH_LOW:  dur = pwle_pkg::at_least_one(cur_bit ? cfg.one_low : cfg.zero_low);
        default:           dur = cfg.gap;
      endcase
      if (cnt2 < dur) begin
        bit_phase_next   = ph1;
        phase_count_next = cnt2;
      end else begin
        phase_count_next = '0;
        unique case (ph1)
          pwle_pkg::PH_GAP:  bit_phase_next = pwle_pkg::PH_HIGH;
          pwle_pkg::PH_HIGH: bit_phase_next = pwle_pkg::PH_LOW;
          pwle_pkg::PH_LOW: begin
            bit_phase_next = pwle_pkg::PH_GAP;
            bit_index_next = bit_index + 1'b1;
            if (bit_index == 3'd7) begin
              byte_new = byte_index + 1'b1;
              adv_byte = 1'b1;
            end
            if (byte_new >= total) begin
              refreshing_next = 1'b0;
              byte_index_next = '0;
              bit_index_next  = '0;
              line_out_next   = 1'b0;
            end else if (adv_byte) begin
              byte_index_next = byte_new;
              cur_byte_next   = next_byte;
              pf_pending_next = ({1'b0, byte_new} + 11'd1) < 11'(pwle_pkg::STORE_BYTES);
            end
          end
          default: bit_phase_next = pwle_pkg::PH_GAP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refreshing  <= 1'b0;
      byte_index  <= '0;
      bit_index   <= '0;
      bit_phase   <= pwle_pkg::PH_GAP;
      phase_count <= '0;
      line_out    <= 1'b0;
      pf_pending  <= 1'b0;
      pf_inflight <= 1'b0;
    end else begin
      refreshing  <= refreshing_next;
      byte_index  <= byte_index_next;
      bit_index   <= bit_index_next;
      bit_phase   <= bit_phase_next;
      phase_count <= phase_count_next;
      line_out    <= line_out_next;
      pf_pending  <= pf_pending_next;
      pf_inflight <= pf_pending;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    if (pf_inflight) begin
      next_byte <= rdata;
    end
  end

  assign stat.refreshing = refreshing;
  assign stat.line_next  = line_out_next;
  assign stat.busy_next  = refreshing_next;
  assign stat.fetch_req  = pf_pending;
  assign stat.fetch_addr = byte_index + 1'b1;

  a_line_low_when_idle: assert property (@(posedge clk) disable iff (rst)
    !refreshing |-> !line_out)
    else $error("line is high outside a refresh");

  a_prefetch_done: assert property (@(posedge clk) disable iff (rst)
    adv_byte |-> (!pf_pending && !pf_inflight))
    else $error("byte advance before the prefetched byte has arrived");

  a_fetch_in_refresh: assert property (@(posedge clk) disable iff (rst)
    pf_pending |-> refreshing)
    else $error("prefetch requested outside a refresh");

endmodule

// ===== src/ws2811_pixel_line_encoder.sv =====
// Top level of the pixel line encoder: handshakes, configuration, pixel store and result register.
`timescale 1ns / 1ps

// Takes one item per clock unless stalled; each result goes through the input register, then the
// result register; with out_ready held high the sustained rate is one item every cycle.
// Each tick item moves the line timing on by one tick, so line timing is counted in items. The
// pixel store is a 768-byte RAM with one read port, used by read items when idle and by the
// byte prefetch during a refresh. After reset the store is cleared in one pass over all 768 bytes,
// during which in_ready stays low; configuration writes are taken at any time.
module ws2811_pixel_line_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pwle_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pwle_pkg::out_item_t             out_data,
  input  logic                            cfg_wen,
  input  logic [pwle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pwle_pkg::timing_cfg_t        cfg;
  logic                         clr_active;
  logic [pwle_pkg::ADDR_W-1:0]  clr_addr;
  logic                         s1_valid;
  pwle_pkg::in_item_t           s1_item;
  logic                         s1_fire;
  logic                         accept;
  logic                         s1_wr;
  logic                         s1_acc;
  logic                         s1_oor;
  logic [7:0]                   s1_byte;
  logic [pwle_pkg::ADDR_W-1:0]  total;
  logic                         fwd_hit;
  logic [7:0]                   fwd_data;
  logic [7:0]                   byte0;
  pwle_pkg::out_item_t          result;
  pwle_pkg::tmr_ctrl_t          tctrl;
  pwle_pkg::tmr_stat_t          tstat;
  logic                         ram_we;
  logic [pwle_pkg::ADDR_W-1:0]  ram_waddr;
  logic [7:0]                   ram_wdata;
  logic                         ram_re;
  logic [pwle_pkg::ADDR_W-1:0]  ram_raddr;
  logic [7:0]                   ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high <= pwle_pkg::TICK_W'(5);
      cfg.zero_low  <= pwle_pkg::TICK_W'(195);
      cfg.one_high  <= pwle_pkg::TICK_W'(150);
      cfg.one_low   <= pwle_pkg::TICK_W'(50);
      cfg.gap       <= pwle_pkg::TICK_W'(50);
      cfg.led_count <= pwle_pkg::LED_W'(50);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pwle_pkg::CFG_ZERO_HIGH: cfg.zero_high <= cfg_wdata;
        pwle_pkg::CFG_ZERO_LOW:  cfg.zero_low  <= cfg_wdata;
        pwle_pkg::CFG_ONE_HIGH:  cfg.one_high  <= cfg_wdata;
        pwle_pkg::CFG_ONE_LOW:   cfg.one_low   <= cfg_wdata;
        pwle_pkg::CFG_GAP:       cfg.gap       <= cfg_wdata;
        pwle_pkg::CFG_LED_COUNT: cfg.led_count <= cfg_wdata[pwle_pkg::LED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == pwle_pkg::ADDR_W'(pwle_pkg::STORE_BYTES - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || s1_fire);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
    if (accept && !tstat.fetch_req) begin
      fwd_hit  <= s1_wr && (s1_item.position == in_data.position);
      fwd_data <= s1_item.value;
    end
  end

  assign total   = pwle_pkg::total_bytes(cfg.led_count);
  assign s1_oor  = s1_item.position >= total;
  assign s1_acc  = (s1_item.command == pwle_pkg::CMD_WRITE) ||
                   (s1_item.command == pwle_pkg::CMD_READ);
  assign s1_wr   = s1_fire && (s1_item.command == pwle_pkg::CMD_WRITE) &&
                   !tstat.refreshing && !s1_oor;
  assign s1_byte = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    result.line_level = tstat.line_next;
    result.busy_res   = tstat.busy_next;
    result.read_data  = '0;
    if (s1_acc && tstat.refreshing) begin
      result.status = pwle_pkg::ST_BUSY;
    end else if (s1_acc && s1_oor) begin
      result.status = pwle_pkg::ST_RANGE;
    end else begin
      result.status = pwle_pkg::ST_OK;
      if (s1_item.command == pwle_pkg::CMD_READ) begin
        result.read_data = s1_byte;
      end
    end
  end

  // Byte 0 is mirrored in a register so that a refresh can start on the cycle after its commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte0 <= '0;
    end else if (s1_wr && s1_item.position == '0) begin
      byte0 <= s1_item.value;
    end
  end

  assign tctrl.tick       = s1_fire && (s1_item.command == pwle_pkg::CMD_TICK);
  assign tctrl.start      = s1_wr && s1_item.commit;
  assign tctrl.start_byte = (s1_item.position == '0) ? s1_item.value : byte0;

  pwle_bit_timer u_timer (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctrl  (tctrl),
    .rdata (ram_rdata),
    .stat  (tstat)
  );

  assign ram_we    = clr_active || s1_wr;
  assign ram_waddr = clr_active ? clr_addr : s1_item.position;
  assign ram_wdata = clr_active ? 8'd0 : s1_item.value;
  assign ram_re    = tstat.fetch_req || accept;
  assign ram_raddr = tstat.fetch_req ? tstat.fetch_addr : in_data.position;

  pwle_ram #(
    .WIDTH (8),
    .DEPTH (pwle_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  a_no_store_write_in_refresh: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clr_active) |-> !tstat.refreshing)
    else $error("pixel store written during a refresh");

  a_prefetch_steals_busy_read: assert property (@(posedge clk) disable iff (rst)
    (tstat.fetch_req && accept) |=> tstat.refreshing)
    else $error("read port taken by the prefetch from an item that is served");

  a_commit_starts_refresh: assert property (@(posedge clk) disable iff (rst)
    tctrl.start |=> tstat.refreshing)
    else $error("committed write did not start a refresh");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pixel line encoder, with a tick-by-tick line timing predictor.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0]                     CMD_SPARE   = 2'd3;
  localparam logic [pwle_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [pwle_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  pwle_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  pwle_pkg::out_item_t             out_data;
  logic                            cfg_wen;
  logic [pwle_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pwle_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ws2811_pixel_line_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predicted state of the encoder.
  logic [7:0]                  pix_mem [pwle_pkg::STORE_BYTES];
  logic [pwle_pkg::TICK_W-1:0] zh_ticks, zl_ticks, oh_ticks, ol_ticks, gap_len;
  logic [pwle_pkg::LED_W-1:0]  led_cnt;
  bit                          refresh_on;
  int unsigned                 byte_idx, bit_idx, phase_cnt;
  pwle_pkg::phase_t            bit_ph;
  bit                          line_lvl;

  pwle_pkg::out_item_t pending_results [$];
  pwle_pkg::out_item_t got_item, want_item;
  int unsigned         mismatch_count = 0;
  int unsigned         active_items;
  bit                  idle_en = 1'b1;

  function automatic void reset_model();
    foreach (pix_mem[i]) pix_mem[i] = 8'h00;
    zh_ticks   = 10'd5;
    zl_ticks   = 10'd195;
    oh_ticks   = 10'd150;
    ol_ticks   = 10'd50;
    gap_len    = 10'd50;
    led_cnt    = 9'd50;
    refresh_on = 1'b0;
    byte_idx   = 0;
    bit_idx    = 0;
    bit_ph     = pwle_pkg::PH_GAP;
    phase_cnt  = 0;
    line_lvl   = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [pwle_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [pwle_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pwle_pkg::CFG_ZERO_HIGH: zh_ticks = data;
      pwle_pkg::CFG_ZERO_LOW:  zl_ticks = data;
      pwle_pkg::CFG_ONE_HIGH:  oh_ticks = data;
      pwle_pkg::CFG_ONE_LOW:   ol_ticks = data;
      pwle_pkg::CFG_GAP:       gap_len = data;
      pwle_pkg::CFG_LED_COUNT: led_cnt = data[pwle_pkg::LED_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned chain_bytes();
    int unsigned n;
    n = led_cnt;
    if (n > pwle_pkg::MAX_LEDS) n = pwle_pkg::MAX_LEDS;
    return 3 * n;
  endfunction

  function automatic bit bit_now();
    if (byte_idx >= pwle_pkg::STORE_BYTES) return 1'b0;
    return pix_mem[byte_idx][7 - bit_idx];
  endfunction

  function automatic int unsigned min_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned phase_ticks();
    bit b;
    b = bit_now();
    case (bit_ph)
      pwle_pkg::PH_GAP:  return gap_len;
      pwle_pkg::PH_HIGH: return min_one(b ? oh_ticks : zh_ticks);
      default:           return min_one(b ? ol_ticks : zl_ticks);
    endcase
  endfunction

  // One tick of line time during a refresh.
  function automatic void advance_line();
    if (bit_ph == pwle_pkg::PH_GAP && phase_cnt >= gap_len) begin
      bit_ph    = pwle_pkg::PH_HIGH;
      phase_cnt = 0;
    end
    line_lvl = (bit_ph == pwle_pkg::PH_HIGH);
    phase_cnt++;
    if (phase_cnt < phase_ticks()) return;
    phase_cnt = 0;
    case (bit_ph)
      pwle_pkg::PH_GAP:  bit_ph = pwle_pkg::PH_HIGH;
      pwle_pkg::PH_HIGH: bit_ph = pwle_pkg::PH_LOW;
      default: begin
        bit_ph = pwle_pkg::PH_GAP;
        bit_idx++;
        if (bit_idx >= 8) begin
          bit_idx = 0;
          byte_idx++;
        end
        if (byte_idx >= chain_bytes()) begin
          refresh_on = 1'b0;
          byte_idx   = 0;
          bit_idx    = 0;
          line_lvl   = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic pwle_pkg::out_item_t encode_item(input pwle_pkg::in_item_t it);
    pwle_pkg::out_item_t r;
    r = '0;
    case (it.command)
      pwle_pkg::CMD_TICK: begin
        if (refresh_on) advance_line();
      end
      pwle_pkg::CMD_WRITE, pwle_pkg::CMD_READ: begin
        if (refresh_on) begin
          r.status = pwle_pkg::ST_BUSY;
        end else if (it.position >= chain_bytes() ||
                     it.position >= pwle_pkg::STORE_BYTES) begin
          r.status = pwle_pkg::ST_RANGE;
        end else if (it.command == pwle_pkg::CMD_READ) begin
          r.read_data = pix_mem[it.position];
        end else begin
          pix_mem[it.position] = it.value;
          if (it.commit) begin
            refresh_on = 1'b1;
            byte_idx   = 0;
            bit_idx    = 0;
            bit_ph     = pwle_pkg::PH_GAP;
            phase_cnt  = 0;
            line_lvl   = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.line_level = line_lvl;
    r.busy_res   = refresh_on;
    return r;
  endfunction

  function automatic pwle_pkg::in_item_t pixel_op(input logic [1:0] cmd, input int unsigned pos,
                                                  input int unsigned val, input bit commit);
    pwle_pkg::in_item_t it;
    it.command  = cmd;
    it.position = pwle_pkg::ADDR_W'(pos);
    it.value    = 8'(val);
    it.commit   = commit;
    return it;
  endfunction

  function automatic pwle_pkg::in_item_t random_noise();
    return pixel_op(2'($urandom_range(3)), $urandom_range(1023), $urandom(),
                    1'($urandom_range(1)));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // All tasks below are entered and left at a falling clock edge.
  task automatic send_item(input pwle_pkg::in_item_t it);
    if (idle_en) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ((it.command == pwle_pkg::CMD_TICK) ? refresh_on :
        (it.command != CMD_SPARE && !refresh_on))
      active_items++;
    pending_results.push_back(encode_item(it));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [pwle_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= pwle_pkg::CFG_DATA_W'(data);
    @(posedge clk);
    apply_reg(idx, pwle_pkg::CFG_DATA_W'(data));
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input int unsigned zh, input int unsigned zl, input int unsigned oh,
                            input int unsigned ol, input int unsigned gap);
    write_reg(pwle_pkg::CFG_ZERO_HIGH, zh);
    write_reg(pwle_pkg::CFG_ZERO_LOW, zl);
    write_reg(pwle_pkg::CFG_ONE_HIGH, oh);
    write_reg(pwle_pkg::CFG_ONE_LOW, ol);
    write_reg(pwle_pkg::CFG_GAP, gap);
  endtask

  // Drops in_valid and waits until every transfer has produced its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic tick_until_idle();
    while (refresh_on) send_item(pixel_op(pwle_pkg::CMD_TICK, $urandom_range(1023), $urandom(), 0));
  endtask

  task automatic test_access_basics();
    send_item(pixel_op(pwle_pkg::CMD_TICK, 1023, 8'hFF, 1));
    send_item(pixel_op(pwle_pkg::CMD_READ, 0, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 0, 8'hFF, 0));
    send_item(pixel_op(pwle_pkg::CMD_READ, 0, 0, 1));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 149, 8'h00, 0));
    send_item(pixel_op(pwle_pkg::CMD_READ, 149, 8'hFF, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 150, 8'h55, 1));
    send_item(pixel_op(pwle_pkg::CMD_READ, 1023, 0, 0));
    send_item(pixel_op(CMD_SPARE, 512, 8'hAA, 1));
    send_item(pixel_op(pwle_pkg::CMD_READ, 150, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 1, 8'hAA, 0));
    send_item(pixel_op(pwle_pkg::CMD_READ, 1, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_TICK, 0, 0, 0));
  endtask

  task automatic test_short_refresh();
    settle();
    set_timing(0, 1, 2, 0, 0);
    write_reg(pwle_pkg::CFG_LED_COUNT, 1);
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 0, 8'h80, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 1, 8'h01, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 2, 8'h5A, 1));
    send_item(pixel_op(pwle_pkg::CMD_READ, 0, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_TICK, 0, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 1, 8'h33, 1));
    send_item(pixel_op(CMD_SPARE, 3, 8'h33, 1));
    tick_until_idle();
    send_item(pixel_op(pwle_pkg::CMD_READ, 2, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_TICK, 0, 0, 0));
    settle();
    set_timing(2, 0, 1, 3, 3);
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 1, 8'hC3, 1));
    tick_until_idle();
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(pwle_pkg::CFG_LED_COUNT, 256);
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 767, 8'h5A, 0));
    send_item(pixel_op(pwle_pkg::CMD_READ, 767, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 768, 8'h11, 1));
    settle();
    write_reg(pwle_pkg::CFG_LED_COUNT, 300);
    send_item(pixel_op(pwle_pkg::CMD_READ, 767, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_READ, 768, 0, 0));
    settle();
    write_reg(pwle_pkg::CFG_LED_COUNT, 0);
    send_item(pixel_op(pwle_pkg::CMD_READ, 0, 0, 0));
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 0, 8'h80, 1));
    settle();
    write_reg(CFG_SPARE_A, 1023);
    write_reg(CFG_SPARE_B, 0);
    set_timing(1023, 1023, 1, 1023, 0);
    write_reg(pwle_pkg::CFG_LED_COUNT, 511);
    send_item(pixel_op(pwle_pkg::CMD_WRITE, 0, 8'h80, 1));
    while (!(bit_ph == pwle_pkg::PH_LOW && phase_cnt > 300)) begin
      send_item(pixel_op(pwle_pkg::CMD_TICK, 0, 0, 0));
    end
    // Shorter durations mid-refresh end the running low phase on the next tick.
    settle();
    set_timing(1, 2, 2, 1, 1);
    while (refresh_on && byte_idx < 4) send_item(pixel_op(pwle_pkg::CMD_TICK, 0, 0, 0));
    // A chain shorter than the byte in progress ends the refresh after the current bit.
    settle();
    write_reg(pwle_pkg::CFG_LED_COUNT, 1);
    tick_until_idle();
  endtask

  task automatic run_traffic_round(input int round_no);
    int                 n;
    int unsigned        led;
    pwle_pkg::in_item_t it;
    settle();
    idle_en = (round_no < 1 || round_no > 2);
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0:       led = 0;
        1:       led = 256;
        2:       led = 511;
        default: led = $urandom_range(511, 3);
      endcase
      write_reg(pwle_pkg::CFG_LED_COUNT, led);
      n = $urandom_range(25, 10);
      repeat (n) begin
        it = pixel_op($urandom_range(1) ? pwle_pkg::CMD_WRITE : pwle_pkg::CMD_READ,
                      $urandom_range(1023), $urandom(), 0);
        send_item(it);
      end
      return;
    end
    set_timing($urandom_range(4), $urandom_range(4), $urandom_range(4), $urandom_range(4),
               $urandom_range(3));
    write_reg(pwle_pkg::CFG_LED_COUNT, ($urandom_range(3) == 0) ? 2 : 1);
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(1023));
    end
    n = $urandom_range(8, 3);
    repeat (n) begin
      case ($urandom_range(9))
        0:       it = random_noise();
        1, 2:    it = pixel_op(pwle_pkg::CMD_READ, $urandom_range(chain_bytes() - 1),
                               $urandom(), 1'($urandom_range(1)));
        default: it = pixel_op(pwle_pkg::CMD_WRITE, $urandom_range(chain_bytes() - 1),
                               $urandom(), 0);
      endcase
      send_item(it);
    end
    send_item(pixel_op(pwle_pkg::CMD_WRITE, $urandom_range(chain_bytes() - 1), $urandom(), 1));
    while (refresh_on) begin
      case ($urandom_range(19))
        0:       it = random_noise();
        1:       it = pixel_op($urandom_range(1) ? pwle_pkg::CMD_WRITE : pwle_pkg::CMD_READ,
                               $urandom_range(chain_bytes() - 1), $urandom(),
                               1'($urandom_range(1)));
        default: it = pixel_op(pwle_pkg::CMD_TICK, $urandom_range(1023), $urandom(),
                               1'($urandom_range(1)));
      endcase
      send_item(it);
    end
    repeat ($urandom_range(3)) begin
      send_item(pixel_op(pwle_pkg::CMD_TICK, $urandom_range(1023), $urandom(),
                         1'($urandom_range(1))));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int          round_no;
    goal     = active_items + 450;
    round_no = 0;
    while (active_items < goal) begin
      run_traffic_round(round_no);
      round_no++;
    end
    idle_en = 1'b1;
  endtask

  always @(negedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= 30);
  end

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_item = out_data;
      if (pending_results.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        want_item = pending_results.pop_front();
        if (got_item.line_level !== want_item.line_level)
          report_mismatch("line_level", got_item.line_level, want_item.line_level);
        if (got_item.read_data !== want_item.read_data)
          report_mismatch("read_data", got_item.read_data, want_item.read_data);
        if (got_item.status !== want_item.status)
          report_mismatch("status", got_item.status, want_item.status);
        if (got_item.busy_res !== want_item.busy_res)
          report_mismatch("busy_res", got_item.busy_res, want_item.busy_res);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_wen        = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    active_items   = 0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_access_basics();
    test_short_refresh();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== ws2811_pixel_line_encoder.f =====
src/pwle_pkg.sv
src/pwle_ram.sv
src/pwle_bit_timer.sv
src/ws2811_pixel_line_encoder.sv
tb/testbench.sv
